// ===== rtl/lzff_pkg.sv =====
// Shared constants and types for the LED zone fractional fill block.
`timescale 1ns / 1ps
package lzff_pkg;
   localparam int LED_COUNT_DEF = 64;

   localparam logic [2:0] ST_VALID    = 3'd0;
   localparam logic [2:0] ST_BAD_DIR  = 3'd1;
   localparam logic [2:0] ST_EMPTY    = 3'd2;
   localparam logic [2:0] ST_RANGE    = 3'd3;
   localparam logic [2:0] ST_ZERO_DEN = 3'd4;

   localparam logic [1:0] DIR_FWD     = 2'd0;
   localparam logic [1:0] DIR_REV     = 2'd1;
   localparam logic [1:0] DIR_CENTRE  = 2'd2;
   localparam logic [1:0] DIR_UNKNOWN = 2'd3;

   localparam logic [1:0] REG_START  = 2'd0;
   localparam logic [1:0] REG_LENGTH = 2'd1;
   localparam logic [1:0] REG_DIR    = 2'd2;

   localparam logic [1:0] CH_LAST = 2'd2;

   localparam int DIV_N = 25;
   localparam int DIV_D = 17;

   typedef enum logic [1:0] {OP_CSCALE, OP_RUN, OP_RSCALE} div_op_type;

   typedef struct packed {
      logic       load;
      logic       div_go;
      div_op_type op;
      logic [1:0] ch;
      logic       emit_init;
      logic       emit_go;
   } cmd_type;

   typedef struct packed {
      logic status_ok;
      logic need_cscale;
      logic need_rscale;
      logic div_done;
      logic out_free;
      logic emit_last;
   } sts_type;
endpackage

// ===== rtl/lzff_if.sv =====
// Request and result channel interfaces.
`timescale 1ns / 1ps
interface lzff_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] fraction_numerator;
   logic [15:0] fraction_denominator;
   logic [7:0]  color_red;
   logic [7:0]  color_green;
   logic [7:0]  color_blue;
   modport source (output valid, fraction_numerator, fraction_denominator,
                   color_red, color_green, color_blue, input ready);
   modport sink (input valid, fraction_numerator, fraction_denominator,
                 color_red, color_green, color_blue, output ready);
endinterface

interface lzff_rsp_if;
   logic       valid;
   logic       ready;
   logic       write_enable;
   logic [5:0] pixel_index;
   logic [7:0] out_red;
   logic [7:0] out_green;
   logic [7:0] out_blue;
   logic [2:0] status;
   logic       last;
   modport source (output valid, write_enable, pixel_index, out_red, out_green,
                   out_blue, status, last, input ready);
   modport sink (input valid, write_enable, pixel_index, out_red, out_green,
                 out_blue, status, last, output ready);
endinterface

// ===== rtl/lzff_div.sv =====
// Restoring radix-2 divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module lzff_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [lzff_pkg::DIV_N-1:0]  dividend,
   input  logic [lzff_pkg::DIV_D-1:0]  divisor,
   output logic                        busy,
   output logic                        done,
   output logic [lzff_pkg::DIV_N-1:0]  quotient,
   output logic [lzff_pkg::DIV_D-1:0]  remainder
);
   localparam int CW = $clog2(lzff_pkg::DIV_N + 1);

   logic [CW-1:0]                cnt_ff, cnt_in;
   logic                         done_ff, done_in;
   logic [lzff_pkg::DIV_N-1:0]   q_ff, q_in;
   logic [lzff_pkg::DIV_D-1:0]   r_ff, r_in;
   logic [lzff_pkg::DIV_D-1:0]   d_ff, d_in;
   logic [lzff_pkg::DIV_D:0]     shifted;
   logic                         fits;

   always_comb begin
      shifted = {r_ff, q_ff[lzff_pkg::DIV_N-1]};
      fits    = shifted >= {1'b0, d_ff};
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      done_in = 1'b0;
      if (start) begin
         cnt_in = CW'(lzff_pkg::DIV_N);
         q_in   = dividend;
         r_in   = '0;
         d_in   = divisor;
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - 1'b1;
         q_in   = {q_ff[lzff_pkg::DIV_N-2:0], fits};
         r_in   = fits ? lzff_pkg::DIV_D'(shifted - {1'b0, d_ff})
                       : shifted[lzff_pkg::DIV_D-1:0];
         done_in = cnt_ff == CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
   end

   assign busy      = cnt_ff != '0;
   assign done      = done_ff;
   assign quotient  = q_ff;
   assign remainder = r_ff;
endmodule

// ===== rtl/lzff_ctrl.sv =====
// Sequencer: zone check, divisions, pixel walk.
`timescale 1ns / 1ps
module lzff_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  lzff_pkg::sts_type sts,
   output lzff_pkg::cmd_type cmd
);
   typedef enum logic [2:0] {
      S_IDLE, S_CHECK, S_DIV_GO, S_DIV_WAIT, S_RCHECK, S_EMIT_INIT, S_EMIT
   } state_type;

   state_type               state_ff;
   lzff_pkg::div_op_type    op_ff;
   logic [1:0]              ch_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         op_ff    <= lzff_pkg::OP_RUN;
         ch_ff    <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: if (req_valid) state_ff <= S_CHECK;
            S_CHECK: begin
               ch_ff <= '0;
               if (!sts.status_ok) begin
                  state_ff <= S_EMIT_INIT;
               end else begin
                  op_ff    <= sts.need_cscale ? lzff_pkg::OP_CSCALE : lzff_pkg::OP_RUN;
                  state_ff <= S_DIV_GO;
               end
            end
            S_DIV_GO: state_ff <= S_DIV_WAIT;
            S_DIV_WAIT: if (sts.div_done) begin
               unique case (op_ff)
                  lzff_pkg::OP_CSCALE: begin
                     state_ff <= S_DIV_GO;
                     if (ch_ff == lzff_pkg::CH_LAST) begin
                        op_ff <= lzff_pkg::OP_RUN;
                        ch_ff <= '0;
                     end else begin
                        ch_ff <= ch_ff + 1'b1;
                     end
                  end
                  lzff_pkg::OP_RUN: state_ff <= S_RCHECK;
                  default: begin
                     if (ch_ff == lzff_pkg::CH_LAST) begin
                        state_ff <= S_EMIT_INIT;
                     end else begin
                        ch_ff    <= ch_ff + 1'b1;
                        state_ff <= S_DIV_GO;
                     end
                  end
               endcase
            end
            S_RCHECK: begin
               ch_ff <= '0;
               if (sts.need_rscale) begin
                  op_ff    <= lzff_pkg::OP_RSCALE;
                  state_ff <= S_DIV_GO;
               end else begin
                  state_ff <= S_EMIT_INIT;
               end
            end
            S_EMIT_INIT: state_ff <= S_EMIT;
            S_EMIT: if (sts.out_free && sts.emit_last) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready     = state_ff == S_IDLE;
   assign cmd.load      = (state_ff == S_IDLE) && req_valid;
   assign cmd.div_go    = state_ff == S_DIV_GO;
   assign cmd.op        = op_ff;
   assign cmd.ch        = ch_ff;
   assign cmd.emit_init = state_ff == S_EMIT_INIT;
   assign cmd.emit_go   = (state_ff == S_EMIT) && sts.out_free;
endmodule

// ===== rtl/lzff_dp.sv =====
// Datapath: zone registers, fill arithmetic, pixel walk, result register.
`timescale 1ns / 1ps
module lzff_dp #(
   parameter int LED_COUNT = lzff_pkg::LED_COUNT_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [6:0]        csr_data,
   input  logic [15:0]       fraction_numerator,
   input  logic [15:0]       fraction_denominator,
   input  logic [7:0]        color_red,
   input  logic [7:0]        color_green,
   input  logic [7:0]        color_blue,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   output logic              write_enable,
   output logic [5:0]        pixel_index,
   output logic [7:0]        out_red,
   output logic [7:0]        out_green,
   output logic [7:0]        out_blue,
   output logic [2:0]        status,
   output logic              last,
   input  lzff_pkg::cmd_type cmd,
   output lzff_pkg::sts_type sts
);
   typedef enum logic [1:0] {PH_CENTRE, PH_RUN0, PH_RUN1} phase_type;

   logic [5:0]  start_ff;
   logic [6:0]  len_ff;
   logic [1:0]  dir_ff;

   logic [22:0] amount_ff;
   logic [15:0] den_ff;
   logic [7:0]  col_ff [3];
   logic [7:0]  cs_ff [3];
   logic [7:0]  rs_ff [3];
   logic [2:0]  st_ff, st_in;
   logic [22:0] whole_ff;
   logic [16:0] rem_ff;

   phase_type   phase_ff;
   logic [6:0]  off_ff, cnt_ff, total_ff, rl_ff;

   logic        rsp_valid_ff;
   logic        we_ff, last_ff;
   logic [5:0]  idx_ff;
   logic [7:0]  red_ff, green_ff, blue_ff;
   logic [2:0]  status_ff;

   logic        dir2, odd, full_centre, need_cscale, cs_nz, rs_nz, centre_e, pflag;
   logic [5:0]  half;
   logic [6:0]  centre7, cap, lit, rl, org, idx7;
   logic [7:0]  total8;
   logic [22:0] runa;
   logic [16:0] unit;
   logic [7:0]  col_sel;
   logic [24:0] dividend;
   logic [16:0] divisor;
   logic        div_busy, div_done;
   logic [24:0] quotient;
   logic [16:0] remainder;
   logic        out_free, emit_last, in_full;
   logic [7:0]  pix [3];

   lzff_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_go),
      .dividend  (dividend),
      .divisor   (divisor),
      .busy      (div_busy),
      .done      (div_done),
      .quotient  (quotient),
      .remainder (remainder)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= '0;
         len_ff   <= '0;
         dir_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            lzff_pkg::REG_START:  start_ff <= csr_data[5:0];
            lzff_pkg::REG_LENGTH: len_ff   <= csr_data;
            lzff_pkg::REG_DIR:    dir_ff   <= csr_data[1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (dir_ff == lzff_pkg::DIR_UNKNOWN) begin
         st_in = lzff_pkg::ST_BAD_DIR;
      end else if (len_ff == '0) begin
         st_in = lzff_pkg::ST_EMPTY;
      end else if (({1'b0, start_ff} >= 7'(LED_COUNT)) ||
                   (len_ff > 7'(LED_COUNT) - {1'b0, start_ff})) begin
         st_in = lzff_pkg::ST_RANGE;
      end else if (fraction_denominator == '0) begin
         st_in = lzff_pkg::ST_ZERO_DEN;
      end else begin
         st_in = lzff_pkg::ST_VALID;
      end
   end

   always_comb begin
      dir2        = dir_ff == lzff_pkg::DIR_CENTRE;
      odd         = len_ff[0];
      half        = len_ff[6:1];
      centre7     = {1'b0, start_ff} + {1'b0, half};
      full_centre = amount_ff >= {7'b0, den_ff};
      need_cscale = dir2 && odd && (amount_ff != '0) && !full_centre;
      runa        = (dir2 && odd) ? ((amount_ff > {7'b0, den_ff}) ?
                                     amount_ff - {7'b0, den_ff} : '0) : amount_ff;
      unit        = dir2 ? {den_ff, 1'b0} : {1'b0, den_ff};
      cap         = dir2 ? {1'b0, half} : len_ff;
      lit         = (whole_ff < {16'b0, cap}) ? whole_ff[6:0] : cap;
      cs_nz       = (cs_ff[0] != '0) || (cs_ff[1] != '0) || (cs_ff[2] != '0);
      rs_nz       = (rs_ff[0] != '0) || (rs_ff[1] != '0) || (rs_ff[2] != '0);
      centre_e    = dir2 && odd && (full_centre || (need_cscale && cs_nz));
      pflag       = (rem_ff != '0) && (lit < cap) && rs_nz;
      rl          = lit + {6'b0, pflag};
      total8      = {7'b0, centre_e} + (dir2 ? {rl, 1'b0} : {1'b0, rl});

      case (cmd.ch)
         2'd0:    col_sel = col_ff[0];
         2'd1:    col_sel = col_ff[1];
         default: col_sel = col_ff[2];
      endcase
      case (cmd.op)
         lzff_pkg::OP_CSCALE: begin
            dividend = 25'(col_sel) * 25'(amount_ff[15:0]);
            divisor  = {1'b0, den_ff};
         end
         lzff_pkg::OP_RSCALE: begin
            dividend = 25'(col_sel) * 25'(rem_ff);
            divisor  = unit;
         end
         default: begin
            dividend = 25'(runa);
            divisor  = unit;
         end
      endcase
   end

   always_comb begin
      unique case (phase_ff)
         PH_RUN1: org = centre7 + {6'b0, odd};
         default: begin
            unique case (dir_ff)
               lzff_pkg::DIR_FWD: org = {1'b0, start_ff};
               lzff_pkg::DIR_REV: org = {1'b0, start_ff} + len_ff - 7'd1;
               default:           org = centre7 - 7'd1;
            endcase
         end
      endcase
      idx7 = ((phase_ff == PH_RUN1) || (dir_ff == lzff_pkg::DIR_FWD)) ?
             org + off_ff : org - off_ff;
      in_full = (phase_ff == PH_CENTRE) ? full_centre : (off_ff < lit);
      for (int k = 0; k < 3; k++) begin
         if (in_full) begin
            pix[k] = col_ff[k];
         end else begin
            pix[k] = (phase_ff == PH_CENTRE) ? cs_ff[k] : rs_ff[k];
         end
      end
      if (phase_ff == PH_CENTRE) idx7 = centre7;
      out_free  = !rsp_valid_ff || rsp_ready;
      emit_last = (total_ff == '0) || (cnt_ff == total_ff - 7'd1);
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         amount_ff <= 23'(len_ff) * 23'(fraction_numerator);
         den_ff    <= fraction_denominator;
         col_ff[0] <= color_red;
         col_ff[1] <= color_green;
         col_ff[2] <= color_blue;
         st_ff     <= st_in;
      end
      if (div_done) begin
         unique case (cmd.op)
            lzff_pkg::OP_CSCALE: cs_ff[cmd.ch] <= quotient[7:0];
            lzff_pkg::OP_RSCALE: rs_ff[cmd.ch] <= quotient[7:0];
            default: begin
               whole_ff <= quotient[22:0];
               rem_ff   <= remainder;
            end
         endcase
      end
      if (cmd.emit_init) begin
         total_ff <= (st_ff == lzff_pkg::ST_VALID) ? total8[6:0] : '0;
         rl_ff    <= rl;
         cnt_ff   <= '0;
         off_ff   <= '0;
         phase_ff <= centre_e ? PH_CENTRE : PH_RUN0;
      end else if (cmd.emit_go) begin
         cnt_ff <= cnt_ff + 7'd1;
         if (phase_ff == PH_CENTRE) begin
            phase_ff <= PH_RUN0;
            off_ff   <= '0;
         end else if (off_ff + 7'd1 < rl_ff) begin
            off_ff <= off_ff + 7'd1;
         end else begin
            phase_ff <= PH_RUN1;
            off_ff   <= '0;
         end
      end
      if (cmd.emit_go) begin
         if (total_ff == '0) begin
            we_ff     <= 1'b0;
            idx_ff    <= '0;
            red_ff    <= '0;
            green_ff  <= '0;
            blue_ff   <= '0;
            status_ff <= st_ff;
         end else begin
            we_ff     <= 1'b1;
            idx_ff    <= idx7[5:0];
            red_ff    <= pix[0];
            green_ff  <= pix[1];
            blue_ff   <= pix[2];
            status_ff <= lzff_pkg::ST_VALID;
         end
         last_ff <= emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign write_enable = we_ff;
   assign pixel_index  = idx_ff;
   assign out_red      = red_ff;
   assign out_green    = green_ff;
   assign out_blue     = blue_ff;
   assign status       = status_ff;
   assign last         = last_ff;

   assign sts.status_ok   = st_ff == lzff_pkg::ST_VALID;
   assign sts.need_cscale = need_cscale;
   assign sts.need_rscale = (rem_ff != '0) && (lit < cap);
   assign sts.div_done    = div_done;
   assign sts.out_free    = out_free;
   assign sts.emit_last   = emit_last;

   a_emit_room: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_go |-> (!rsp_valid_ff || rsp_ready))
      else $error("result pushed over a waiting item");
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.div_go |-> !div_busy)
      else $error("divider restarted while busy");
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_go && total_ff == '0) |-> emit_last)
      else $error("empty item not marked last");
   a_off_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_go && total_ff != '0 && phase_ff != PH_CENTRE) |-> (off_ff < rl_ff))
      else $error("pixel walk past run end");
endmodule

// ===== rtl/led_zone_fractional_fill_unit.sv =====
// Top level of the LED zone fractional fill block.
// The first result follows one divide, or up to seven divides when both the
// centre pixel and the partial pixel need scaling.
// Results then stream one per cycle unless the output stalls, up to 64 per item.
// One item at a time; the iterative divider and the pixel walk set the rate.
// Synchronous active-high reset clears the zone registers and the sequencer.
`timescale 1ns / 1ps
module led_zone_fractional_fill_unit #(
   parameter int LED_COUNT = lzff_pkg::LED_COUNT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   lzff_req_if.sink    req_ch,
   lzff_rsp_if.source  rsp_ch,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [6:0]  csr_data
);
   lzff_pkg::cmd_type cmd;
   lzff_pkg::sts_type sts;

   lzff_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   lzff_dp #(.LED_COUNT(LED_COUNT)) u_dp (
      .clock                (clock),
      .reset                (reset),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_data             (csr_data),
      .fraction_numerator   (req_ch.fraction_numerator),
      .fraction_denominator (req_ch.fraction_denominator),
      .color_red            (req_ch.color_red),
      .color_green          (req_ch.color_green),
      .color_blue           (req_ch.color_blue),
      .rsp_ready            (rsp_ch.ready),
      .rsp_valid            (rsp_ch.valid),
      .write_enable         (rsp_ch.write_enable),
      .pixel_index          (rsp_ch.pixel_index),
      .out_red              (rsp_ch.out_red),
      .out_green            (rsp_ch.out_green),
      .out_blue             (rsp_ch.out_blue),
      .status               (rsp_ch.status),
      .last                 (rsp_ch.last),
      .cmd                  (cmd),
      .sts                  (sts)
   );
endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the LED zone fractional fill unit.
`timescale 1ns / 1ps
module tb_top;
   localparam int LEDS = 64;
   localparam int CYCLE_LIMIT = 1500000;
   localparam int SETTLE = 300;

   typedef struct {
      logic       we;
      logic [5:0] idx;
      logic [7:0] r, g, b;
      logic [2:0] st;
      logic       last;
   } pixel_write_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic       csr_we = 1'b0;
   logic [1:0] csr_index = '0;
   logic [6:0] csr_data = '0;

   lzff_req_if req();
   lzff_rsp_if rsp();

   led_zone_fractional_fill_unit dut (
      .clock(clock), .reset(reset), .req_ch(req), .rsp_ch(rsp),
      .csr_we(csr_we), .csr_index(csr_index), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   // predictor copy of the zone registers
   int unsigned zstart = 0, zlen = 0, zdir = 0;
   pixel_write_type pending_writes[$];
   pixel_write_type item_writes[$];
   int errors = 0, cycles = 0, items_sent = 0, writes_seen = 0;
   int tx_idle = 0, rx_idle = 0, hold_cycles = 0;

   initial begin
      req.valid = 1'b0;
      req.fraction_numerator = '0;
      req.fraction_denominator = '0;
      req.color_red = '0;
      req.color_green = '0;
      req.color_blue = '0;
      rsp.ready = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("tb_top: errors");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp.ready <= 1'b0;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp.ready <= ($urandom_range(99) >= rx_idle);
      end
   end

   task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
         $error("%s: expected %0d, got %0d", name, exp_v, act_v);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      pixel_write_type e;
      if (!reset && rsp.valid && rsp.ready) begin
         writes_seen++;
         if (pending_writes.size() == 0) begin
            $error("unexpected result item, pixel_index %0d", rsp.pixel_index);
            errors++;
         end else begin
            e = pending_writes.pop_front();
            check_field("write_enable", e.we, rsp.write_enable);
            check_field("pixel_index", e.idx, rsp.pixel_index);
            check_field("out_red", e.r, rsp.out_red);
            check_field("out_green", e.g, rsp.out_green);
            check_field("out_blue", e.b, rsp.out_blue);
            check_field("status", e.st, rsp.status);
            check_field("last", e.last, rsp.last);
         end
      end
   end

   function automatic void push_write(logic we, int unsigned idx, int unsigned r,
                                      int unsigned g, int unsigned b);
      pixel_write_type w;
      if (item_writes.size() >= LEDS) return;
      w.we = we; w.idx = idx[5:0]; w.r = r[7:0]; w.g = g[7:0]; w.b = b[7:0];
      w.st = lzff_pkg::ST_VALID; w.last = 1'b0;
      item_writes.push_back(w);
   endfunction

   function automatic void dim_pixel(int unsigned idx, int unsigned c[3],
                                     int unsigned part, int unsigned whole_unit);
      int unsigned r, g, b;
      if (whole_unit == 0) return;
      r = c[0] * part / whole_unit;
      g = c[1] * part / whole_unit;
      b = c[2] * part / whole_unit;
      if (r == 0 && g == 0 && b == 0) return;
      push_write(1'b1, idx, r, g, b);
   endfunction

   function automatic void fill_run(int unsigned origin, bit up, int unsigned cap,
                                    int unsigned amount, int unsigned unit_sz,
                                    int unsigned c[3]);
      int unsigned lit, rem;
      if (unit_sz == 0) return;
      lit = amount / unit_sz;
      if (lit > cap) lit = cap;
      for (int unsigned k = 0; k < lit; k++)
         push_write(1'b1, up ? origin + k : origin - k, c[0], c[1], c[2]);
      rem = amount % unit_sz;
      if (rem != 0 && lit < cap)
         dim_pixel(up ? origin + lit : origin - lit, c, rem, unit_sz);
   endfunction

   function automatic void predict_fill(int unsigned num, int unsigned den,
                                        int unsigned c[3]);
      logic [2:0] st;
      int unsigned amount, half, centre, side, right;
      pixel_write_type w;
      item_writes.delete();
      if (zdir > lzff_pkg::DIR_CENTRE) st = lzff_pkg::ST_BAD_DIR;
      else if (zlen == 0) st = lzff_pkg::ST_EMPTY;
      else if (zstart >= LEDS || zlen > LEDS - zstart) st = lzff_pkg::ST_RANGE;
      else if (den == 0) st = lzff_pkg::ST_ZERO_DEN;
      else st = lzff_pkg::ST_VALID;
      if (st == lzff_pkg::ST_VALID) begin
         amount = zlen * num;
         if (zdir == lzff_pkg::DIR_FWD) fill_run(zstart, 1, zlen, amount, den, c);
         else if (zdir == lzff_pkg::DIR_REV)
            fill_run(zstart + zlen - 1, 0, zlen, amount, den, c);
         else begin
            half = zlen / 2;
            centre = zstart + half;
            side = amount;
            right = centre;
            if (zlen % 2 == 1) begin
               if (amount >= den) push_write(1'b1, centre, c[0], c[1], c[2]);
               else if (amount != 0) dim_pixel(centre, c, amount, den);
               side = amount > den ? amount - den : 0;
               right = centre + 1;
            end
            if (half != 0 && side != 0) begin
               fill_run(centre - 1, 0, half, side, 2 * den, c);
               fill_run(right, 1, half, side, 2 * den, c);
            end
         end
      end
      if (item_writes.size() == 0) push_write(1'b0, 0, 0, 0, 0);
      w = item_writes.pop_back();
      w.st = st;
      w.last = 1'b1;
      item_writes.push_back(w);
      foreach (item_writes[i]) pending_writes.push_back(item_writes[i]);
   endfunction

   task automatic send_item(int unsigned num, int unsigned den, int unsigned r,
                            int unsigned g, int unsigned b);
      int unsigned c[3];
      @(negedge clock);
      while ($urandom_range(99) < tx_idle) begin
         req.valid <= 1'b0;
         @(negedge clock);
      end
      req.valid <= 1'b1;
      req.fraction_numerator <= num[15:0];
      req.fraction_denominator <= den[15:0];
      req.color_red <= r[7:0];
      req.color_green <= g[7:0];
      req.color_blue <= b[7:0];
      do @(posedge clock); while (!(req.valid && req.ready));
      c[0] = r & 8'hFF; c[1] = g & 8'hFF; c[2] = b & 8'hFF;
      predict_fill(num & 16'hFFFF, den & 16'hFFFF, c);
      items_sent++;
   endtask

   task automatic drain();
      @(negedge clock);
      req.valid <= 1'b0;
      while (pending_writes.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, int unsigned data);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_data <= data[6:0];
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == lzff_pkg::REG_START) zstart = data & 6'h3F;
      else if (idx == lzff_pkg::REG_LENGTH) zlen = data & 7'h7F;
      else if (idx == lzff_pkg::REG_DIR) zdir = data & 2'h3;
   endtask

   task automatic set_zone(int unsigned s, int unsigned l, int unsigned d);
      drain();
      write_reg(lzff_pkg::REG_START, s);
      write_reg(lzff_pkg::REG_LENGTH, l);
      write_reg(lzff_pkg::REG_DIR, d);
   endtask

   task automatic send_random_item();
      int unsigned den, num, lim;
      case ($urandom_range(19))
         0: den = 0;
         1, 2, 3, 4, 5, 6: den = $urandom_range(1, 16);
         7, 8: den = 16'hFFFF;
         default: den = $urandom_range(1, 65535);
      endcase
      lim = den + den / 4 + 1;
      if (lim > 65535) lim = 65535;
      if ($urandom_range(9) == 0) num = $urandom_range(65535);
      else num = $urandom_range(0, lim);
      if ($urandom_range(15) == 0)
         send_item(num, den, 0, 0, $urandom_range(1));
      else
         send_item(num, den, $urandom_range(255), $urandom_range(255), $urandom_range(255));
   endtask

   task automatic random_zone();
      int unsigned s, l, d;
      s = $urandom_range(63);
      if ($urandom_range(9) < 8) l = $urandom_range(1, 64 - s);
      else l = $urandom_range(127);
      d = ($urandom_range(9) == 0) ? lzff_pkg::DIR_UNKNOWN : $urandom_range(2);
      if ($urandom_range(3) == 0) s = $urandom_range(1) ? 0 : 64 - l % 65;
      set_zone(s % 64, l, d);
   endtask

   task automatic test_errors();
      send_item(1, 1, 255, 255, 255);
      set_zone(0, 8, lzff_pkg::DIR_UNKNOWN);
      send_item(1, 2, 10, 20, 30);
      set_zone(60, 10, lzff_pkg::DIR_FWD);
      send_item(1, 2, 10, 20, 30);
      set_zone(63, 1, lzff_pkg::DIR_FWD);
      send_item(1, 0, 10, 20, 30);
      set_zone(0, 127, lzff_pkg::DIR_REV);
      send_item(1, 1, 10, 20, 30);
   endtask

   task automatic test_linear_fills();
      set_zone(0, 64, lzff_pkg::DIR_FWD);
      send_item(0, 65535, 255, 255, 255);
      send_item(65535, 65535, 255, 255, 255);
      send_item(65535, 1, 255, 0, 255);
      send_item(3, 10, 200, 100, 50);
      send_item(1, 1000, 1, 1, 1);
      set_zone(63, 1, lzff_pkg::DIR_REV);
      send_item(1, 2, 255, 128, 3);
      send_item(1, 1, 0, 0, 0);
      set_zone(10, 20, lzff_pkg::DIR_REV);
      send_item(7, 9, 99, 17, 240);
      send_item(2, 3, 0, 0, 0);
   endtask

   task automatic test_centre_fills();
      set_zone(5, 9, lzff_pkg::DIR_CENTRE);
      send_item(1, 18, 255, 255, 255);
      send_item(1, 9, 100, 200, 50);
      send_item(5, 9, 100, 200, 50);
      send_item(2, 1, 100, 200, 50);
      set_zone(0, 64, lzff_pkg::DIR_CENTRE);
      send_item(1, 2, 12, 34, 56);
      send_item(33, 64, 255, 1, 128);
      set_zone(40, 1, lzff_pkg::DIR_CENTRE);
      send_item(1, 3, 255, 255, 255);
      set_zone(20, 2, lzff_pkg::DIR_CENTRE);
      send_item(1, 4, 255, 255, 255);
   endtask

   task automatic test_random_items(int unsigned count);
      for (int unsigned p = 0; p < 3; p++) begin
         tx_idle = (p == 0) ? 33 : (p == 1) ? 79 : 0;
         rx_idle = (p == 0) ? 79 : (p == 1) ? 33 : 0;
         for (int unsigned i = 0; i < count / 3; i++) begin
            if (i % 10 == 0) random_zone();
            send_random_item();
         end
      end
      tx_idle = 0;
      rx_idle = 0;
   endtask

   task automatic test_backpressure();
      set_zone(0, 64, lzff_pkg::DIR_FWD);
      hold_cycles = 600;
      for (int unsigned i = 0; i < 6; i++)
         send_item(65535, 65535, $urandom_range(255), $urandom_range(255), 255);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_errors();
      test_linear_fills();
      test_centre_fills();
      test_random_items(123);
      test_backpressure();
      drain();
      $display("covered %0d items and %0d result items across error, linear and centre fills",
               items_sent, writes_seen);
      $display("with random stalls on both sides and one long output hold-off");
      if (errors == 0) $display("tb_top: clean");
      else $display("tb_top: errors");
      $finish;
   end
endmodule
